[design/two_class_priority_list_assert.svh]
// ----------------------------------------------------------------------------
// Two-class priority list assertion macros
// Shared property templates, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_PRIORITY_LIST_ASSERT_SVH
`define TWO_CLASS_PRIORITY_LIST_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCPL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("two_class_priority_list: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TCPL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("two_class_priority_list: next-cycle check failed");

`endif

[design/tcpl_pkg.sv]
// ----------------------------------------------------------------------------
// Two-class priority list package
// Item types, status codes and fixed constants shared by the list modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpl_pkg;

  // Slot index width covers lists of up to 256 entries.
  localparam int SLOT_W = 8;

  localparam logic [6:0] THRESHOLD_RESET = 7'd60;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] entry_id;
    logic [6:0]  entry_age;
    logic [5:0]  position;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] removed_id;
    logic [5:0]  occupancy;
    logic [5:0]  priority_occupancy;
  } out_item_t;

  // Command broadcast to every cell of the list.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       id;
  } cell_cmd_t;

endpackage

`default_nettype wire

[design/tcpl_cell.sv]
// ----------------------------------------------------------------------------
// Two-class priority list cell
// Holds one entry id and shifts towards either neighbour on insert or remove.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpl_cell #(
  parameter int IDX = 0
) (
  input  wire                 clk,
  input  tcpl_pkg::cell_cmd_t cmd,
  input  wire  [15:0]         left_id,
  input  wire  [15:0]         right_id,
  output logic [15:0]         id_q,
  output logic [15:0]         sel_id
);
  import tcpl_pkg::*;

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

  logic [15:0] id_r;
  logic [15:0] id_nxt;
  logic        at_slot;
  logic        past_slot;

  assign at_slot   = (cmd.slot == MY_SLOT);
  assign past_slot = (cmd.slot < MY_SLOT);

  always_comb begin
    id_nxt = id_r;
    if (cmd.ins) begin
      if (at_slot) begin
        id_nxt = cmd.id;
      end else if (past_slot) begin
        id_nxt = left_id;
      end
    end else if (cmd.rem) begin
      // The gap closes by pulling every later entry one place forward.
      if (at_slot || past_slot) begin
        id_nxt = right_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign id_q   = id_r;
  assign sel_id = at_slot ? id_r : 16'd0;

endmodule

`default_nettype wire

[design/two_class_priority_list.sv]
// ----------------------------------------------------------------------------
// Two-class priority list
// The result of an item is registered and on out_item in the cycle after acceptance.
// Throughput: one item per cycle while out_ready keeps in_ready high; every cell shifts in parallel.
// Reset: synchronous rst_n clears both counts, the result valid and sets the
// threshold to 60; the cell contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_priority_list #(
  parameter int DEPTH = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  tcpl_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output tcpl_pkg::out_item_t out_item,
  input  wire                 cfg_we,
  input  wire  [6:0]          cfg_wdata
);
  import tcpl_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] pcnt_r, pcnt_nxt;
  logic [6:0]    thr_r;
  logic          out_valid_r;
  out_item_t     out_item_r, out_item_nxt;

  logic            acc, is_ins, full, prio, bad_pos, rem_in_prio;
  logic            do_ins, do_rem;
  logic [CMPW-1:0] pos_ext, cnt_ext, pcnt_ext, cnt_nxt_ext, pcnt_nxt_ext;
  logic [CW-1:0]   ins_slot;
  cell_cmd_t       cmd;
  logic [15:0]     rd_id;

  logic [15:0] cell_id [DEPTH];
  logic [15:0] sel_id  [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign is_ins   = (in_item.kind == KIND_INSERT);

  assign pos_ext  = CMPW'(in_item.position);
  assign cnt_ext  = CMPW'(cnt_r);
  assign pcnt_ext = CMPW'(pcnt_r);

  assign full        = (cnt_r == CW'(DEPTH));
  assign prio        = (in_item.entry_age >= thr_r);
  assign bad_pos     = (in_item.position == 6'd0) || (pos_ext > cnt_ext);
  // A removed entry is priority class when it sits among the first pcnt.
  assign rem_in_prio = (pos_ext <= pcnt_ext);

  assign do_ins = acc && is_ins && !full;
  assign do_rem = acc && !is_ins && !bad_pos;

  assign ins_slot = prio ? pcnt_r : cnt_r;

  always_comb begin
    cmd.ins  = do_ins;
    cmd.rem  = do_rem;
    cmd.id   = in_item.entry_id;
    cmd.slot = is_ins ? SLOT_W'(ins_slot)
                      : (SLOT_W'(in_item.position) - SLOT_W'(1));
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [15:0] left_id;
    logic [15:0] right_id;

    if (i == 0) begin : g_first
      assign left_id = 16'd0;
    end else begin : g_mid_l
      assign left_id = cell_id[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_id = 16'd0;
    end else begin : g_mid_r
      assign right_id = cell_id[i+1];
    end

    tcpl_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .left_id  (left_id),
      .right_id (right_id),
      .id_q     (cell_id[i]),
      .sel_id   (sel_id[i])
    );
  end

  always_comb begin
    rd_id = 16'd0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_id = rd_id | sel_id[i];
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    pcnt_nxt = pcnt_r;
    if (do_ins) begin
      cnt_nxt = cnt_r + CW'(1);
      if (prio) begin
        pcnt_nxt = pcnt_r + CW'(1);
      end
    end else if (do_rem) begin
      cnt_nxt = cnt_r - CW'(1);
      if (rem_in_prio) begin
        pcnt_nxt = pcnt_r - CW'(1);
      end
    end
  end

  assign cnt_nxt_ext  = CMPW'(cnt_nxt);
  assign pcnt_nxt_ext = CMPW'(pcnt_nxt);

  always_comb begin
    out_item_nxt.status             = ST_OK;
    out_item_nxt.removed_id         = 16'd0;
    out_item_nxt.occupancy          = cnt_nxt_ext[5:0];
    out_item_nxt.priority_occupancy = pcnt_nxt_ext[5:0];
    if (is_ins) begin
      if (full) begin
        out_item_nxt.status = ST_FULL;
      end
    end else if (bad_pos) begin
      out_item_nxt.status = ST_BAD_POS;
    end else begin
      out_item_nxt.removed_id = rd_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pcnt_r      <= '0;
      thr_r       <= THRESHOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pcnt_r <= pcnt_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

[design/tcpl_checker.sv]
// ----------------------------------------------------------------------------
// Two-class priority list checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_class_priority_list_assert.svh"

module tcpl_checker #(
  parameter int DEPTH = 32
) (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input tcpl_pkg::out_item_t out_item
);
  import tcpl_pkg::*;

  localparam int          CW       = $clog2(DEPTH + 1);
  localparam logic [CW:0] DEPTH_C  = (CW + 1)'(DEPTH);
  localparam logic [5:0]  DEPTH_LO = 6'(DEPTH_C);

  // Every accepted item shows a result in the following cycle.
  `TCPL_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid)

  // A stalled result holds still.
  `TCPL_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(out_item))

  // A failed operation never returns an id.
  `TCPL_ASSERT_SAME(a_fail_no_id, out_valid && (out_item.status != ST_OK),
                    out_item.removed_id == 16'd0)

  // A full report only comes with a full list.
  `TCPL_ASSERT_SAME(a_full_count, out_valid && (out_item.status == ST_FULL),
                    out_item.occupancy == DEPTH_LO)

  // Priority entries are a subset of all entries while counts do not wrap.
  `TCPL_ASSERT_SAME(a_prio_subset, (DEPTH < 64) && out_valid,
                    out_item.priority_occupancy <= out_item.occupancy)

endmodule

bind two_class_priority_list tcpl_checker #(
  .DEPTH (DEPTH)
) u_tcpl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

[tb/sv/tb_two_class_priority_list.sv]
// ----------------------------------------------------------------------------
// Two-class priority list testbench
// Drives random insert and remove items through the list with random gaps
// and back-pressure, across several threshold settings, and checks every
// result against a shadow copy of the list kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_two_class_priority_list;
  import tcpl_pkg::*;

  localparam int DEPTH          = 32;
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PASS = 180;
  localparam int WATCHDOG_LIMIT = 200;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_we    = 1'b0;
  logic [6:0] cfg_wdata = '0;

  two_class_priority_list #(.DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Shadow of the list contents, counts and threshold.
  logic [15:0] shadow_ids [DEPTH];
  int          shadow_count    = 0;
  int          shadow_priority = 0;
  logic [6:0]  shadow_threshold = THRESHOLD_RESET;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];

  int   in_gap_max    = 9;
  int   out_stall_max = 9;
  int   in_gap        = 0;
  int   out_stall     = 0;
  logic in_taken      = 1'b0;
  logic out_taken     = 1'b0;
  int   idle_cycles   = 0;
  int   mismatch_count = 0;
  int   queued_count  = 0;

  int n_insert = 0, n_priority_insert = 0, n_full = 0;
  int n_remove = 0, n_bad_position = 0, n_settings = 1;

  function automatic out_item_t apply_to_list(in_item_t it);
    out_item_t res;
    int        slot;
    int        k;
    res = '0;
    res.status = ST_OK;
    if (it.kind == KIND_INSERT) begin
      n_insert++;
      if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
        n_full++;
      end else begin
        if (it.entry_age >= shadow_threshold) begin
          slot = shadow_priority;
          shadow_priority++;
          n_priority_insert++;
        end else begin
          slot = shadow_count;
        end
        for (k = shadow_count; k > slot; k--) shadow_ids[k] = shadow_ids[k - 1];
        shadow_ids[slot] = it.entry_id;
        shadow_count++;
      end
    end else begin
      n_remove++;
      if (it.position == 0 || it.position > shadow_count) begin
        res.status = ST_BAD_POS;
        n_bad_position++;
      end else begin
        slot = it.position - 1;
        res.removed_id = shadow_ids[slot];
        for (k = slot; k + 1 < shadow_count; k++) shadow_ids[k] = shadow_ids[k + 1];
        shadow_count--;
        // The class of a removed entry follows from where it sits.
        if (slot < shadow_priority) shadow_priority--;
      end
    end
    res.occupancy = shadow_count[5:0];
    res.priority_occupancy = shadow_priority[5:0];
    return res;
  endfunction

  // Sampling, prediction and checking at the rising edge.
  always @(posedge clk) begin
    out_item_t want;
    in_taken  <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
    if (rst_n) begin
      if (cfg_we) shadow_threshold = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result with nothing expected: status %0d removed_id %h occ %0d prio %0d",
                     out_item.status, out_item.removed_id, out_item.occupancy,
                     out_item.priority_occupancy);
        end else begin
          want = expected_results.pop_front();
          if (out_item.status !== want.status || out_item.removed_id !== want.removed_id ||
              out_item.occupancy !== want.occupancy ||
              out_item.priority_occupancy !== want.priority_occupancy) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch (expected/actual): status %0d/%0d removed_id %h/%h ",
                        "occ %0d/%0d prio %0d/%0d"},
                       want.status, out_item.status, want.removed_id, out_item.removed_id,
                       want.occupancy, out_item.occupancy,
                       want.priority_occupancy, out_item.priority_occupancy);
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(apply_to_list(in_item));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Input driver: the gap drawn with an item is spent after it is accepted.
  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
      // hold the item until it is accepted
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap   <= in_gap - 1;
    end else if (pending_items.size() > 0) begin
      in_item  <= pending_items.pop_front();
      in_valid <= 1'b1;
      in_gap   <= $urandom_range(0, in_gap_max);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result side back-pressure, drawn afresh after every taken result.
  always @(negedge clk) begin
    int stall;
    stall = out_taken ? $urandom_range(0, out_stall_max) : out_stall;
    if (stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= stall - 1;
    end else begin
      out_ready <= 1'b1;
      out_stall <= 0;
    end
  end

  // Occupancy as the generator sees it, so that remove positions can be aimed.
  int gen_count = 0;

  task automatic queue_item(input logic kind, input logic [15:0] id,
                            input logic [6:0] age, input logic [5:0] pos);
    in_item_t it;
    it.kind      = kind;
    it.entry_id  = id;
    it.entry_age = age;
    it.position  = pos;
    if (kind == KIND_INSERT) begin
      if (gen_count < DEPTH) gen_count++;
    end else if (pos != 0 && pos <= gen_count) begin
      gen_count--;
    end
    pending_items.push_back(it);
    queued_count++;
  endtask

  task automatic queue_random(input int insert_pct, input logic [6:0] threshold);
    logic [5:0] pos;
    logic [6:0] age;
    int         r;
    pos = 6'($urandom);
    age = 7'($urandom);
    r   = $urandom_range(0, 9);
    if ($urandom_range(0, 99) < insert_pct) begin
      // Ages just below and at the threshold are where the class is decided.
      if (r < 3) age = threshold - 7'(r % 2);
      queue_item(KIND_INSERT, 16'($urandom), age, pos);
    end else begin
      if (gen_count > 0 && r < 7) pos = 6'($urandom_range(1, gen_count));
      else if (r == 7) pos = 6'(gen_count + 1);
      queue_item(KIND_REMOVE, 16'($urandom), age, pos);
    end
  endtask

  task automatic wait_until_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    logic [6:0] threshold;
    int         insert_pct;
    int         ph;
    int         i;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening at the reset threshold of 60.
    queue_item(KIND_REMOVE, 16'h0000, 7'd0,   6'd1);   // remove from an empty list
    queue_item(KIND_REMOVE, 16'h0000, 7'd0,   6'd0);   // position zero
    queue_item(KIND_INSERT, 16'h0000, 7'd0,   6'd0);   // ordinary entry to the tail
    queue_item(KIND_INSERT, 16'hFFFF, 7'd127, 6'd63);  // priority entry to the front
    queue_item(KIND_INSERT, 16'h1234, 7'd60,  6'd0);   // exactly at the threshold
    queue_item(KIND_INSERT, 16'h5A5A, 7'd59,  6'd0);   // just below the threshold
    queue_item(KIND_REMOVE, 16'h0000, 7'd0,   6'd63);  // far beyond the count
    queue_item(KIND_REMOVE, 16'h0000, 7'd0,   6'd5);   // one beyond the count
    queue_item(KIND_REMOVE, 16'h0000, 7'd0,   6'd2);   // priority entry
    queue_item(KIND_REMOVE, 16'h0000, 7'd0,   6'd3);   // tail entry
    queue_item(KIND_REMOVE, 16'h0000, 7'd0,   6'd1);
    queue_item(KIND_REMOVE, 16'h0000, 7'd0,   6'd1);   // list empty again
    queue_item(KIND_INSERT, 16'hAAAA, 7'd100, 6'h2A);
    queue_item(KIND_INSERT, 16'h5555, 7'd0,   6'h15);
    queue_item(KIND_REMOVE, 16'h0000, 7'd127, 6'd2);

    for (ph = 0; ph < PHASES; ph++) begin
      threshold = THRESHOLD_RESET;
      if (ph > 0) begin
        wait_until_idle();
        case (ph)
          1: threshold = 7'd0;
          2: threshold = 7'd127;
          4: threshold = 7'd1;
          5: threshold = 7'd126;
          default: threshold = 7'($urandom);
        endcase
        cfg_we    <= 1'b1;
        cfg_wdata <= threshold;
        @(negedge clk);
        cfg_we    <= 1'b0;
        n_settings++;
        in_gap_max    = (ph == 1 || ph == 6) ? 0 : 9;
        out_stall_max = (ph == 2 || ph == 6) ? 0 : 9;
      end
      // Entries held over from the last phase keep their class.
      for (i = 0; i < ITEMS_PER_PASS; i++) begin
        if (i % 40 == 0) begin
          case ($urandom_range(0, 2))
            0: insert_pct = 25;
            1: insert_pct = 50;
            default: insert_pct = 85;
          endcase
        end
        queue_random(insert_pct, threshold);
      end
    end

    wait_until_idle();
    $display("%0d items: %0d inserts (%0d priority class, %0d refused on a full list)",
             queued_count, n_insert, n_priority_insert, n_full);
    $display("%0d removes (%0d at a bad position) over %0d threshold settings",
             n_remove, n_bad_position, n_settings);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
